// File: design/ilsr_pkg.sv
package ilsr_pkg;

  // operation codes carried by in_kind
  typedef enum logic [2:0] {
    OP_READ   = 3'd0,
    OP_WRITE  = 3'd1,
    OP_APPEND = 3'd2,
    OP_REMOVE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // fixed field widths of the channels
  localparam int KIND_BITS  = 3;
  localparam int INDEX_BITS = 4;
  localparam int VALUE_BITS = 32;
  localparam int COUNT_BITS = 5;

  // broadcast to every cell of the row
  typedef struct packed {
    logic wr;   // overwrite the entry at the index
    logic app;  // load the entry at the current count
    logic rm;   // shift entries above the index down by one
  } cell_ctl_t;

endpackage

// File: design/ilsr_cell.sv
module ilsr_cell #(
  parameter int WORD_BITS = 32,
  parameter int CMP_W     = 5,
  parameter int POS       = 0
) (
  input  logic                   clk,
  input  ilsr_pkg::cell_ctl_t    ctl,
  input  logic [CMP_W-1:0]       idx,
  input  logic [CMP_W-1:0]       cnt,
  input  logic [WORD_BITS-1:0]   word_in,
  input  logic [WORD_BITS-1:0]   next_in,
  output logic [WORD_BITS-1:0]   q
);
  import ilsr_pkg::*;

  localparam logic [CMP_W-1:0] MY_POS   = CMP_W'(POS);
  localparam logic [CMP_W:0]   POS_NEXT = (CMP_W + 1)'(POS + 1);

  logic [WORD_BITS-1:0] entry_r;
  logic [WORD_BITS-1:0] entry_nxt;
  logic                 hit_idx;
  logic                 at_end;
  logic                 in_tail;

  // position compares against the broadcast index and count
  assign hit_idx = (idx == MY_POS);
  assign at_end  = (cnt == MY_POS);
  assign in_tail = (idx <= MY_POS) && (POS_NEXT < {1'b0, cnt});

  // load, shift from the upper neighbor, or hold
  always_comb begin
    priority if (ctl.wr && hit_idx) begin
      entry_nxt = word_in;
    end else if (ctl.app && at_end) begin
      entry_nxt = word_in;
    end else if (ctl.rm && in_tail) begin
      entry_nxt = next_in;
    end else begin
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign q = entry_r;

endmodule

// File: design/ilsr_ctrl.sv
module ilsr_ctrl #(
  parameter int DEPTH = 16,
  parameter int CNT_W = 5,
  parameter int CMP_W = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ilsr_pkg::KIND_BITS-1:0] in_kind,
  input  logic [CMP_W-1:0]              idx,
  input  logic [ilsr_pkg::VALUE_BITS-1:0] rd_data,
  output ilsr_pkg::cell_ctl_t           ctl,
  output logic [CMP_W-1:0]              cnt,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ilsr_pkg::VALUE_BITS-1:0] out_data,
  output logic [1:0]                    out_status,
  output logic [ilsr_pkg::COUNT_BITS-1:0] out_count,
  output logic                          out_empty_res
);
  import ilsr_pkg::*;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [CNT_W-1:0]      cnt_r;
  logic [CNT_W-1:0]      cnt_nxt;
  logic [VALUE_BITS-1:0] data_r;
  logic [VALUE_BITS-1:0] data_nxt;
  status_t               status_r;
  status_t               status_nxt;
  logic [COUNT_BITS-1:0] count_r;
  logic                  empty_r;
  logic                  fire;
  logic                  in_range;
  logic [CNT_W-1:0]      cnt_op;
  cell_ctl_t             ctl_op;

  // input taken whenever the result register is free or drains
  assign in_stall = out_valid_r & out_stall;
  assign fire     = in_valid & ~in_stall;
  assign cnt      = CMP_W'(cnt_r);
  assign in_range = (idx < CMP_W'(cnt_r));

  // decode of the operation
  always_comb begin
    cnt_op     = cnt_r;
    data_nxt   = '0;
    status_nxt = ST_OK;
    ctl_op     = '0;
    unique case (op_t'(in_kind))
      OP_READ: begin
        if (in_range) data_nxt = rd_data;
        else status_nxt = ST_RANGE;
      end
      OP_WRITE: begin
        if (in_range) ctl_op.wr = 1'b1;
        else status_nxt = ST_RANGE;
      end
      OP_APPEND: begin
        if (cnt_r < FULL_CNT) begin
          ctl_op.app = 1'b1;
          cnt_op     = cnt_r + CNT_ONE;
        end else begin
          status_nxt = ST_FULL;
        end
      end
      OP_REMOVE: begin
        if (in_range) begin
          ctl_op.rm = 1'b1;
          data_nxt  = rd_data;
          cnt_op    = cnt_r - CNT_ONE;
        end else begin
          status_nxt = ST_RANGE;
        end
      end
      OP_CLEAR: begin
        cnt_op = '0;
      end
      default: begin
        cnt_op = cnt_r;
      end
    endcase
  end

  // cell commands only on an accepted transaction
  always_comb begin
    ctl.wr  = fire & ctl_op.wr;
    ctl.app = fire & ctl_op.app;
    ctl.rm  = fire & ctl_op.rm;
    cnt_nxt = fire ? cnt_op : cnt_r;
    out_valid_nxt = fire | (out_valid_r & out_stall);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (fire) begin
      data_r   <= data_nxt;
      status_r <= status_nxt;
      count_r  <= COUNT_BITS'(cnt_op);
      empty_r  <= (cnt_op == '0);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = data_r;
  assign out_status    = status_r;
  assign out_count     = count_r;
  assign out_empty_res = empty_r;

endmodule

// File: design/indexed_list_with_shift_remove.sv
// channel  | handshake           | payload
// ---------+---------------------+-----------------------------------------
// in       | in_valid, in_stall  | in_kind, in_index, in_value
// out      | out_valid, out_stall| out_data, out_status, out_count,
//          |                     | out_empty_res
//
// one operation per cycle while in_stall is low: every operation, remove
// included, completes in the cycle it is accepted, since each cell of the
// entry row loads, shifts from its upper neighbor or holds at that clock
// edge; the result is registered and appears in the cycle after acceptance.
// synchronous reset empties the list; entry contents are not cleared.
// in_stall is high only while a result waits and out_stall holds it.
module indexed_list_with_shift_remove #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ilsr_pkg::KIND_BITS-1:0]  in_kind,
  input  logic [ilsr_pkg::INDEX_BITS-1:0] in_index,
  input  logic [ilsr_pkg::VALUE_BITS-1:0] in_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ilsr_pkg::VALUE_BITS-1:0] out_data,
  output logic [1:0]                      out_status,
  output logic [ilsr_pkg::COUNT_BITS-1:0] out_count,
  output logic                            out_empty_res
);
  import ilsr_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = (CNT_W > INDEX_BITS) ? CNT_W : INDEX_BITS;

  logic [WORD_BITS-1:0]  q_w [DEPTH];
  logic [WORD_BITS-1:0]  word_in;
  logic [WORD_BITS-1:0]  rd_word;
  logic [63:0]           value_wide;
  logic [63:0]           rd_wide;
  logic [VALUE_BITS-1:0] rd_data;
  logic [CMP_W-1:0]      idx_ext;
  logic [CMP_W-1:0]      cnt;
  cell_ctl_t             ctl;

  // value kept to the word width, read word back to the field width
  assign value_wide = 64'(in_value);
  assign word_in    = value_wide[WORD_BITS-1:0];
  assign idx_ext    = CMP_W'(in_index);
  assign rd_word    = q_w[idx_ext[IDX_W-1:0]];
  assign rd_wide    = 64'(rd_word);
  assign rd_data    = rd_wide[VALUE_BITS-1:0];

  ilsr_ctrl #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W),
    .CMP_W (CMP_W)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .idx           (idx_ext),
    .rd_data       (rd_data),
    .ctl           (ctl),
    .cnt           (cnt),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .out_status    (out_status),
    .out_count     (out_count),
    .out_empty_res (out_empty_res)
  );

  // row of entry cells, each fed by its upper neighbor, the top cell by itself
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] next_w;
    if (i == DEPTH - 1) begin : g_last
      assign next_w = q_w[i];
    end else begin : g_mid
      assign next_w = q_w[i+1];
    end
    ilsr_cell #(
      .WORD_BITS (WORD_BITS),
      .CMP_W     (CMP_W),
      .POS       (i)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .idx     (idx_ext),
      .cnt     (cnt),
      .word_in (word_in),
      .next_in (next_w),
      .q       (q_w[i])
    );
  end

endmodule

// File: test/indexed_list_with_shift_remove_test.sv
module indexed_list_with_shift_remove_test;
  import ilsr_pkg::*;

  localparam int LIST_DEPTH  = 16;
  localparam int ITEM_TARGET = 450;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [KIND_BITS-1:0]  in_kind;
  logic [INDEX_BITS-1:0] in_index;
  logic [VALUE_BITS-1:0] in_value;
  logic                  out_valid;
  logic                  out_stall;
  logic [VALUE_BITS-1:0] out_data;
  logic [1:0]            out_status;
  logic [COUNT_BITS-1:0] out_count;
  logic                  out_empty_res;

  // one predicted response of the list
  typedef struct {
    logic [VALUE_BITS-1:0] data;
    status_t               status;
    logic [COUNT_BITS-1:0] count;
    logic                  empty;
  } list_result_t;

  // shadow list and queue of predicted responses
  class list_scoreboard;
    logic [VALUE_BITS-1:0] words [LIST_DEPTH];
    int unsigned           held;
    list_result_t          awaited [$];
    int unsigned           fails;

    function new();
      held  = 0;
      fails = 0;
    endfunction

    // apply one accepted operation to the shadow list
    function void note_op(logic [KIND_BITS-1:0] kind, logic [INDEX_BITS-1:0] index,
                          logic [VALUE_BITS-1:0] value);
      list_result_t res;
      bit           hit;
      res.data   = '0;
      res.status = ST_OK;
      hit        = index < held;
      case (kind)
        OP_READ: begin
          if (hit) res.data = words[index];
          else res.status = ST_RANGE;
        end
        OP_WRITE: begin
          if (hit) words[index] = value;
          else res.status = ST_RANGE;
        end
        OP_APPEND: begin
          if (held < LIST_DEPTH) begin
            words[INDEX_BITS'(held)] = value;
            held++;
          end else begin
            res.status = ST_FULL;
          end
        end
        OP_REMOVE: begin
          if (hit) begin
            res.data = words[index];
            // later entries move down to close the gap
            for (int i = int'(index); i + 1 < held; i++) begin
              words[INDEX_BITS'(i)] = words[INDEX_BITS'(i + 1)];
            end
            held--;
          end else begin
            res.status = ST_RANGE;
          end
        end
        OP_CLEAR: begin
          held = 0;
        end
        default: begin
        end
      endcase
      res.count = held[COUNT_BITS-1:0];
      res.empty = (held == 0);
      awaited.push_back(res);
    endfunction

    // compare one response with the oldest prediction
    function void check_result(logic [VALUE_BITS-1:0] data, logic [1:0] status,
                               logic [COUNT_BITS-1:0] count, logic empty);
      list_result_t want;
      if (awaited.size() == 0) begin
        $error("response with no transaction outstanding, data %0h", data);
        fails++;
        return;
      end
      want = awaited.pop_front();
      if (data !== want.data) begin
        $error("data: expected %0h, actual %0h", want.data, data);
        fails++;
      end
      if (status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, status);
        fails++;
      end
      if (count !== want.count) begin
        $error("count: expected %0d, actual %0d", want.count, count);
        fails++;
      end
      if (empty !== want.empty) begin
        $error("empty_res: expected %0d, actual %0d", want.empty, empty);
        fails++;
      end
    endfunction
  endclass

  list_scoreboard list_model;
  bit             idle_on;
  bit             stall_on;
  int unsigned    items_sent;
  int unsigned    gen_count;

  indexed_list_with_shift_remove u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_index     (in_index),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .out_status   (out_status),
    .out_count    (out_count),
    .out_empty_res(out_empty_res)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // random back-pressure on the response side
  always @(posedge clk) begin
    out_stall <= stall_on && ($urandom_range(0, 99) < 20);
  end

  // watch both channels; inputs are noted before responses are checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) list_model.note_op(in_kind, in_index, in_value);
      if (out_valid && !out_stall) begin
        list_model.check_result(out_data, out_status, out_count, out_empty_res);
      end
    end
  end

  // present one operation and hold it until the block takes it
  task automatic send_op(input logic [KIND_BITS-1:0] kind,
                         input logic [INDEX_BITS-1:0] index,
                         input logic [VALUE_BITS-1:0] value);
    while (idle_on && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_index <= index;
    in_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    // rough count used only to steer the random mix
    case (kind)
      OP_APPEND: if (gen_count < LIST_DEPTH) gen_count++;
      OP_REMOVE: if (index < gen_count) gen_count--;
      OP_CLEAR:  gen_count = 0;
      default: begin
      end
    endcase
  endtask

  // stop sending until every response is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (list_model.awaited.size() != 0) @(posedge clk);
  endtask

  // one random operation, mostly aimed at live entries
  task automatic random_op();
    int unsigned           pick;
    logic [INDEX_BITS-1:0] idx;
    logic [VALUE_BITS-1:0] word;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) word = $urandom_range(0, 1) ? '1 : '0;
    else word = $urandom;
    if (gen_count > 0 && $urandom_range(0, 99) < 85) begin
      idx = INDEX_BITS'($urandom_range(0, gen_count - 1));
    end else begin
      idx = INDEX_BITS'($urandom_range(0, LIST_DEPTH - 1));
    end
    if (gen_count == 0 && pick < 60) pick = 0;
    if (pick < 35) send_op(OP_APPEND, idx, word);
    else if (pick < 55) send_op(OP_READ, idx, word);
    else if (pick < 72) send_op(OP_WRITE, idx, word);
    else if (pick < 94) send_op(OP_REMOVE, idx, word);
    else if (pick < 98) send_op(OP_CLEAR, idx, word);
    else send_op(KIND_BITS'($urandom_range(5, 7)), idx, word);
  endtask

  // main sequence
  initial begin
    bit mid_drained;
    list_model  = new();
    idle_on     = 1'b1;
    stall_on    = 1'b1;
    items_sent  = 0;
    gen_count   = 0;
    mid_drained = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_kind   <= '0;
    in_index  <= '0;
    in_value  <= '0;
    out_stall <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // operations on the empty list, unknown kinds included
    send_op(OP_READ, 4'd15, '0);
    send_op(OP_WRITE, 4'd0, '1);
    send_op(OP_REMOVE, 4'd0, '0);
    send_op(OP_CLEAR, 4'd0, '0);
    send_op(KIND_BITS'(5), 4'd0, '0);
    send_op(KIND_BITS'(7), 4'd15, '1);

    // fill to capacity with extreme and random words, then overflow
    send_op(OP_APPEND, 4'd15, '0);
    send_op(OP_APPEND, 4'd0, '1);
    repeat (LIST_DEPTH - 2) send_op(OP_APPEND, 4'd0, $urandom);
    send_op(OP_APPEND, 4'd0, 32'hA5A5_5A5A);

    // last entry, shift-removes at both ends, write and stale index
    send_op(OP_READ, 4'd15, '0);
    send_op(OP_REMOVE, 4'd15, '0);
    send_op(OP_REMOVE, 4'd0, '0);
    send_op(OP_WRITE, 4'd13, '1);
    send_op(OP_READ, 4'd14, '0);
    send_op(OP_READ, 4'd13, '0);
    send_op(OP_CLEAR, 4'd0, '0);
    drain();

    // random operations with occasional bursts of appends up to full
    while (items_sent < ITEM_TARGET) begin
      idle_on  = !(items_sent >= 200 && items_sent < 300);
      stall_on = idle_on;
      if (!mid_drained && items_sent >= 350) begin
        drain();
        mid_drained = 1'b1;
      end
      if ($urandom_range(0, 99) < 3) begin
        repeat ($urandom_range(10, 18)) begin
          send_op(OP_APPEND, INDEX_BITS'($urandom_range(0, 15)), $urandom);
        end
      end else begin
        random_op();
      end
    end

    stall_on = 1'b1;
    drain();
    repeat (8) @(posedge clk);
    if (list_model.fails == 0 && list_model.awaited.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(12 * 300000);
    $display("status: fail");
    $finish;
  end

endmodule
